// ===== rtl/qlt_pkg.sv =====
// Shared types and constants for the quoted line tokenizer.
// Holds character codes, result categories, the integer parse phases and
// the register map; used by rtl/quoted_line_tokenizer.sv.
package qlt_pkg;

  // Result category of one character
  typedef enum logic [1:0] {
    CAT_SEP   = 2'd0,
    CAT_MARK  = 2'd1,
    CAT_TOKEN = 2'd2,
    CAT_EOL   = 2'd3
  } category_t;

  // Phase of the running atoi parse of the current token
  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  // Register map, word index into the APB space
  typedef enum logic [2:0] {
    REG_HIDDEN_MARK = 3'd0,
    REG_SEPARATOR_A = 3'd1,
    REG_SEPARATOR_B = 3'd2,
    REG_SEPARATOR_C = 3'd3,
    REG_SEPARATOR_D = 3'd4,
    REG_SEPARATOR_E = 3'd5
  } reg_index_t;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // Register reset values
  localparam logic [7:0] HIDDEN_MARK_RST = 8'hFF;
  localparam logic [7:0] SEPARATOR_A_RST = 8'h20;
  localparam logic [7:0] SEPARATOR_B_RST = 8'h09;
  localparam logic [7:0] SEPARATOR_C_RST = 8'h2C;
  localparam logic [7:0] SEPARATOR_D_RST = 8'h3D;
  localparam logic [7:0] SEPARATOR_E_RST = 8'h1A;

  // Character codes
  localparam logic [7:0] CHAR_EOL   = 8'h00;
  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_BIT   = 8'h20;

  // Integer saturation
  localparam logic [31:0] MAG_CAP = 32'h8000_0000;
  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;

endpackage

// ===== rtl/quoted_line_tokenizer.sv =====
// Quoted line tokenizer: classifies one character per word and tracks tokens.
// Top level; depends on rtl/qlt_pkg.sv.
//
// Usage
//   Character channel: char_valid / char_stall / char_in, one byte per word.
//   A zero byte ends the line and clears all line state (quoted and hidden
//   modes, position, token count, overflow flag).
//   Result channel: result_valid / result_stall and one result word per
//   character: category, token index and start location, lower-case byte,
//   token end with index and saturated atoi value, running count, overflow
//   and quoted mode after the byte.
//   APB port: six byte registers at 4*i (hidden mark, separators a..e);
//   pready is always high. Write only while no word is in flight.
// Timing
//   The accepting edge loads the input register; the result register is
//   loaded, and result_valid raised, once it is empty or not stalled,
//   with one pass of classify/parse logic between.
//   Throughput is one word per cycle while result_stall is low; the integer
//   update (multiply by ten as shift-add plus saturate) is the longest path.
// Reset and stall
//   rst clears the pipeline and line state and loads register defaults.
//   When the receiver stalls, the result holds, the input register holds,
//   and char_stall rises only once both are full.
module quoted_line_tokenizer #(
  parameter int unsigned MAX_TOKENS  = 32,
  parameter int unsigned LINE_LENGTH = 1024,
  localparam int unsigned CW = $clog2(MAX_TOKENS + 1),
  localparam int unsigned DW = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1,
  localparam int unsigned LW = $clog2(LINE_LENGTH)
) (
  input  logic                      clk,
  input  logic                      rst,
  // APB configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [qlt_pkg::ADDR_W-1:0] paddr,
  input  logic [qlt_pkg::DATA_W-1:0] pwdata,
  output logic [qlt_pkg::DATA_W-1:0] prdata,
  output logic                      pready,
  // character channel
  input  logic                      char_valid,
  output logic                      char_stall,
  input  logic [7:0]                char_in,
  // result channel
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic [1:0]                category,
  output logic [CW-1:0]             token_index,
  output logic [LW-1:0]             token_location,
  output logic [7:0]                lower_char,
  output logic                      token_done,
  output logic [DW-1:0]             done_index,
  output logic signed [31:0]        done_integer,
  output logic [CW-1:0]             token_count,
  output logic                      token_overflow,
  output logic                      in_quotes
);
  import qlt_pkg::*;

  // configuration registers
  logic [7:0] hidden_mark;
  logic [7:0] separator_a, separator_b, separator_c, separator_d, separator_e;

  // input register
  logic       ch_valid;
  logic [7:0] ch;

  // line state
  logic          quoted_mode, hidden_mode, skip_flag, in_token, overflow_flag;
  logic [LW-1:0] line_position, start_location;
  logic [CW-1:0] tokens_seen;
  phase_t        number_phase;
  logic          number_negative;
  logic [31:0]   number_accumulator;

  // next values
  logic          quoted_mode_next, hidden_mode_next, skip_flag_next, in_token_next;
  logic          overflow_flag_next;
  logic [LW-1:0] line_position_next, start_location_next;
  logic [CW-1:0] tokens_seen_next;
  phase_t        number_phase_next;
  logic          number_negative_next;
  logic [31:0]   number_accumulator_next;

  logic          advance;
  logic          wr_en;
  category_t     cat;
  logic          is_sep, is_digit, is_space, is_sign;
  logic          token_start, done;
  phase_t        ph_eff;
  logic          neg_eff;
  logic [31:0]   acc_eff, acc_mac, value;
  logic [35:0]   prod;
  logic [LW-1:0] start_calc;

  // APB access
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      hidden_mark <= HIDDEN_MARK_RST;
      separator_a <= SEPARATOR_A_RST;
      separator_b <= SEPARATOR_B_RST;
      separator_c <= SEPARATOR_C_RST;
      separator_d <= SEPARATOR_D_RST;
      separator_e <= SEPARATOR_E_RST;
    end else if (wr_en) begin
      case (reg_index_t'(paddr[4:2]))
        REG_HIDDEN_MARK: hidden_mark <= pwdata[7:0];
        REG_SEPARATOR_A: separator_a <= pwdata[7:0];
        REG_SEPARATOR_B: separator_b <= pwdata[7:0];
        REG_SEPARATOR_C: separator_c <= pwdata[7:0];
        REG_SEPARATOR_D: separator_d <= pwdata[7:0];
        REG_SEPARATOR_E: separator_e <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index_t'(paddr[4:2]))
      REG_HIDDEN_MARK: prdata = {24'd0, hidden_mark};
      REG_SEPARATOR_A: prdata = {24'd0, separator_a};
      REG_SEPARATOR_B: prdata = {24'd0, separator_b};
      REG_SEPARATOR_C: prdata = {24'd0, separator_c};
      REG_SEPARATOR_D: prdata = {24'd0, separator_d};
      REG_SEPARATOR_E: prdata = {24'd0, separator_e};
      default:         prdata = '0;
    endcase
  end

  // pipeline flow: advance the input word into the result register
  assign advance    = ch_valid && (!result_valid || !result_stall);
  assign char_stall = ch_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      ch_valid <= 1'b0;
    end else if (!char_stall) begin
      ch_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && !char_stall) begin
      ch <= char_in;
    end
  end

  // classify the character
  assign is_sep = (separator_a != 8'd0 && ch == separator_a) ||
                  (separator_b != 8'd0 && ch == separator_b) ||
                  (separator_c != 8'd0 && ch == separator_c) ||
                  (separator_d != 8'd0 && ch == separator_d) ||
                  (separator_e != 8'd0 && ch == separator_e);

  always_comb begin
    quoted_mode_next = quoted_mode;
    hidden_mode_next = hidden_mode;
    if (ch == CHAR_EOL) begin
      cat              = CAT_EOL;
      quoted_mode_next = 1'b0;
    end else if (hidden_mode) begin
      cat = CAT_MARK;
      if (ch == hidden_mark) hidden_mode_next = 1'b0;
    end else if (!quoted_mode) begin
      if (ch == hidden_mark) begin
        cat              = CAT_MARK;
        hidden_mode_next = 1'b1;
      end else if (ch == CHAR_QUOTE) begin
        cat              = CAT_MARK;
        quoted_mode_next = 1'b1;
      end else if (is_sep) begin
        cat = CAT_SEP;
      end else begin
        cat = CAT_TOKEN;
      end
    end else if (ch == CHAR_QUOTE) begin
      cat              = CAT_MARK;
      quoted_mode_next = 1'b0;
    end else begin
      cat = CAT_TOKEN;
    end
  end

  // running atoi: whitespace, optional sign, then digits
  assign token_start = (cat == CAT_TOKEN) && !in_token;
  assign is_digit    = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
  assign is_space    = (ch == CHAR_SPACE) || ((ch >= CHAR_TAB) && (ch <= CHAR_CR));
  assign is_sign     = (ch == CHAR_PLUS) || (ch == CHAR_MINUS);
  assign ph_eff      = token_start ? PH_LEAD : number_phase;
  assign neg_eff     = token_start ? 1'b0 : number_negative;
  assign acc_eff     = token_start ? 32'd0 : number_accumulator;

  // multiply by ten as shift-add, saturate at the magnitude cap
  assign prod    = ({4'd0, acc_eff} << 3) + ({4'd0, acc_eff} << 1) + {32'd0, ch[3:0]};
  assign acc_mac = (prod > {4'd0, MAG_CAP}) ? MAG_CAP : prod[31:0];

  always_comb begin
    number_phase_next       = number_phase;
    number_negative_next    = number_negative;
    number_accumulator_next = number_accumulator;
    if (cat == CAT_TOKEN) begin
      number_phase_next       = ph_eff;
      number_negative_next    = neg_eff;
      number_accumulator_next = acc_eff;
      case (ph_eff)
        PH_LEAD: begin
          if (is_sign) begin
            number_negative_next = (ch == CHAR_MINUS);
            number_phase_next    = PH_DIGITS;
          end else if (is_digit) begin
            number_phase_next       = PH_DIGITS;
            number_accumulator_next = acc_mac;
          end else if (!is_space) begin
            number_phase_next = PH_DONE;
          end
        end
        PH_DIGITS: begin
          if (is_digit) number_accumulator_next = acc_mac;
          else          number_phase_next       = PH_DONE;
        end
        default: ;
      endcase
    end
  end

  // saturated value of the token that ends here
  always_comb begin
    if (number_negative) begin
      value = (number_accumulator >= MAG_CAP) ? MAG_CAP : (32'd0 - number_accumulator);
    end else begin
      value = (number_accumulator >= MAG_CAP) ? SAT_POS : number_accumulator;
    end
  end

  // token bookkeeping
  assign start_calc = (line_position == '0 && skip_flag) ? LW'(LINE_LENGTH - 1)
                                                         : line_position - LW'(skip_flag);
  assign done = (cat == CAT_SEP || cat == CAT_EOL) && in_token &&
                (tokens_seen < CW'(MAX_TOKENS));

  always_comb begin
    start_location_next = token_start ? start_calc : start_location;
    overflow_flag_next  = overflow_flag ||
                          (token_start && tokens_seen >= CW'(MAX_TOKENS));
    tokens_seen_next    = tokens_seen + CW'(done);
    skip_flag_next      = skip_flag;
    in_token_next       = in_token;
    case (cat)
      CAT_TOKEN: in_token_next = 1'b1;
      CAT_MARK:  if (!in_token) skip_flag_next = (ch == CHAR_QUOTE);
      CAT_SEP: begin
        in_token_next  = 1'b0;
        skip_flag_next = 1'b1;
      end
      default:   in_token_next = 1'b0;
    endcase
    line_position_next = (line_position == LW'(LINE_LENGTH - 1)) ? '0
                                                                  : line_position + LW'(1);
  end

  // update line state; clear it after end of line
  always_ff @(posedge clk) begin
    if (rst) begin
      quoted_mode        <= 1'b0;
      hidden_mode        <= 1'b0;
      skip_flag          <= 1'b0;
      in_token           <= 1'b0;
      overflow_flag      <= 1'b0;
      line_position      <= '0;
      start_location     <= '0;
      tokens_seen        <= '0;
      number_phase       <= PH_LEAD;
      number_negative    <= 1'b0;
      number_accumulator <= '0;
    end else if (advance) begin
      if (cat == CAT_EOL) begin
        quoted_mode        <= 1'b0;
        hidden_mode        <= 1'b0;
        skip_flag          <= 1'b0;
        in_token           <= 1'b0;
        overflow_flag      <= 1'b0;
        line_position      <= '0;
        start_location     <= '0;
        tokens_seen        <= '0;
        number_phase       <= PH_LEAD;
        number_negative    <= 1'b0;
        number_accumulator <= '0;
      end else begin
        quoted_mode        <= quoted_mode_next;
        hidden_mode        <= hidden_mode_next;
        skip_flag          <= skip_flag_next;
        in_token           <= in_token_next;
        overflow_flag      <= overflow_flag_next;
        line_position      <= line_position_next;
        start_location     <= start_location_next;
        tokens_seen        <= tokens_seen_next;
        number_phase       <= number_phase_next;
        number_negative    <= number_negative_next;
        number_accumulator <= number_accumulator_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      category       <= cat;
      token_index    <= tokens_seen;
      token_location <= start_location_next;
      lower_char     <= (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) ? (ch | CASE_BIT) : ch;
      token_done     <= done;
      done_index     <= done ? tokens_seen[DW-1:0] : '0;
      done_integer   <= done ? value : 32'sd0;
      token_count    <= tokens_seen_next;
      token_overflow <= overflow_flag_next;
      in_quotes      <= quoted_mode_next;
    end
  end

`ifndef SYNTHESIS
  // a finished token bumps the count to one past its index
  a_done_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && token_done |-> token_count == CW'(done_index) + CW'(1))
    else $error("token count does not follow finished token index");

  // the count only moves on a finished token
  a_count_moves: assert property (@(posedge clk) disable iff (rst)
    result_valid && token_count != token_index |-> token_done)
    else $error("token count changed without a finished token");

  // no integer reported without a finished token
  a_idle_integer: assert property (@(posedge clk) disable iff (rst)
    result_valid && !token_done |-> done_integer == 32'sd0)
    else $error("integer reported without a finished token");

  // end of line always leaves quoted mode
  a_eol_quotes: assert property (@(posedge clk) disable iff (rst)
    result_valid && category == CAT_EOL |-> !in_quotes)
    else $error("quoted mode survives end of line");

  // hidden and quoted modes exclude each other
  a_modes: assert property (@(posedge clk) disable iff (rst)
    !(hidden_mode && quoted_mode))
    else $error("hidden and quoted modes both set");

  // token count never passes the table size
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    tokens_seen <= CW'(MAX_TOKENS))
    else $error("token count beyond table size");
`endif

endmodule

// ===== tb/sv/quoted_line_tokenizer_tb.sv =====
// Self-checking testbench for the quoted line tokenizer: random lines and
// register settings, results predicted in a scoreboard class.
// Depends on rtl/qlt_pkg.sv and rtl/quoted_line_tokenizer.sv.
`timescale 1ns / 100ps

module quoted_line_tokenizer_tb;
  import qlt_pkg::*;

  localparam int unsigned TOKEN_SLOTS = 32;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // One result word as seen on the result channel
  typedef struct {
    category_t          category;
    logic [5:0]         token_index;
    logic [9:0]         token_location;
    logic [7:0]         lower_char;
    logic               token_done;
    logic [4:0]         done_index;
    logic signed [31:0] done_integer;
    logic [5:0]         token_count;
    logic               token_overflow;
    logic               in_quotes;
  } token_result_t;

  // Tracks the line state of the tokenizer and holds the results still owed
  class token_scoreboard;
    logic [7:0]    mark_byte;
    logic [7:0]    separators [5];
    bit            quoted, hidden, skip, in_tok, overflow;
    logic [9:0]    position, start_loc;
    logic [5:0]    seen;
    phase_t        phase;
    bit            negative;
    logic [31:0]   magnitude;
    token_result_t owed_q[$];
    int            errors;

    function new();
      mark_byte     = HIDDEN_MARK_RST;
      separators[0] = SEPARATOR_A_RST;
      separators[1] = SEPARATOR_B_RST;
      separators[2] = SEPARATOR_C_RST;
      separators[3] = SEPARATOR_D_RST;
      separators[4] = SEPARATOR_E_RST;
      errors = 0;
      clear_line();
    endfunction

    function void clear_line();
      quoted = 0; hidden = 0; skip = 0; in_tok = 0; overflow = 0;
      position = '0; start_loc = '0; seen = '0;
      phase = PH_LEAD; negative = 0; magnitude = '0;
    endfunction

    function void set_register(reg_index_t idx, logic [7:0] value);
      if (idx == REG_HIDDEN_MARK) mark_byte = value;
      else separators[idx - REG_SEPARATOR_A] = value;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function bit is_separator(logic [7:0] c);
      foreach (separators[i]) if (separators[i] != 8'h00 && c == separators[i]) return 1;
      return 0;
    endfunction

    // Classify one byte and update quoted and hidden modes
    function category_t classify(logic [7:0] c);
      if (c == CHAR_EOL) begin
        quoted = 0;
        return CAT_EOL;
      end
      if (hidden) begin
        if (c == mark_byte) hidden = 0;
        return CAT_MARK;
      end
      if (!quoted) begin
        if (c == mark_byte) begin
          hidden = 1;
          return CAT_MARK;
        end
        if (c == CHAR_QUOTE) begin
          quoted = 1;
          return CAT_MARK;
        end
        if (is_separator(c)) return CAT_SEP;
        return CAT_TOKEN;
      end
      if (c == CHAR_QUOTE) begin
        quoted = 0;
        return CAT_MARK;
      end
      return CAT_TOKEN;
    endfunction

    // Advance the atoi parse by one token byte
    function void feed_number(logic [7:0] c);
      bit          digit;
      logic [63:0] product;
      digit = (c >= CHAR_ZERO && c <= CHAR_NINE);
      if (phase == PH_LEAD) begin
        if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) return;
        if (c == CHAR_PLUS || c == CHAR_MINUS) begin
          negative = (c == CHAR_MINUS);
          phase = PH_DIGITS;
          return;
        end
        phase = digit ? PH_DIGITS : PH_DONE;
      end
      if (phase == PH_DIGITS) begin
        if (digit) begin
          product = {32'd0, magnitude} * 64'd10 + 64'(c - CHAR_ZERO);
          magnitude = (product > 64'(MAG_CAP)) ? MAG_CAP : product[31:0];
        end else begin
          phase = PH_DONE;
        end
      end
    endfunction

    function logic [31:0] number_value();
      if (negative) return (magnitude >= MAG_CAP) ? MAG_CAP : 32'd0 - magnitude;
      return (magnitude >= MAG_CAP) ? SAT_POS : magnitude;
    endfunction

    // Work out the result word that an accepted byte causes
    function void note_char(logic [7:0] c);
      token_result_t r;
      category_t     cat;
      r.token_index = seen;
      cat = classify(c);
      r.category = cat;
      r.lower_char = (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ? c + CASE_BIT : c;
      r.token_done = 0;
      r.done_index = '0;
      r.done_integer = '0;
      if (cat == CAT_TOKEN) begin
        if (!in_tok) begin
          in_tok = 1;
          // 10-bit wrap gives the modulo of the line length
          start_loc = position - 10'(skip);
          if (seen >= TOKEN_SLOTS) overflow = 1;
          phase = PH_LEAD; negative = 0; magnitude = '0;
        end
        feed_number(c);
      end else if (cat == CAT_MARK) begin
        if (!in_tok) skip = (c == CHAR_QUOTE);
      end else begin
        if (in_tok) begin
          if (seen < TOKEN_SLOTS) begin
            r.token_done = 1;
            r.done_index = seen[4:0];
            r.done_integer = number_value();
            seen++;
          end
          in_tok = 0;
        end
        if (cat == CAT_SEP) skip = 1;
      end
      r.token_location = start_loc;
      r.token_count = seen;
      r.token_overflow = overflow;
      r.in_quotes = quoted;
      owed_q.push_back(r);
      if (cat == CAT_EOL) clear_line();
      else position = position + 10'd1;
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        errors++;
      end
    endfunction

    // Match a delivered result word against the oldest one owed
    function void check_result(token_result_t got);
      token_result_t want;
      if (owed_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      want = owed_q.pop_front();
      compare_field("category", 32'(want.category), 32'(got.category));
      compare_field("token_index", 32'(want.token_index), 32'(got.token_index));
      compare_field("token_location", 32'(want.token_location), 32'(got.token_location));
      compare_field("lower_char", 32'(want.lower_char), 32'(got.lower_char));
      compare_field("token_done", 32'(want.token_done), 32'(got.token_done));
      compare_field("done_index", 32'(want.done_index), 32'(got.done_index));
      compare_field("done_integer", want.done_integer, got.done_integer);
      compare_field("token_count", 32'(want.token_count), 32'(got.token_count));
      compare_field("token_overflow", 32'(want.token_overflow), 32'(got.token_overflow));
      compare_field("in_quotes", 32'(want.in_quotes), 32'(got.in_quotes));
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [ADDR_W-1:0]         paddr = '0;
  logic [DATA_W-1:0]         pwdata = '0;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;
  logic                      char_valid = 1'b0;
  logic                      char_stall;
  logic [7:0]                char_in = 8'h00;
  logic                      result_valid;
  logic                      result_stall = 1'b0;
  logic [1:0]                category;
  logic [5:0]                token_index;
  logic [9:0]                token_location;
  logic [7:0]                lower_char;
  logic                      token_done;
  logic [4:0]                done_index;
  logic signed [31:0]        done_integer;
  logic [5:0]                token_count;
  logic                      token_overflow;
  logic                      in_quotes;

  token_scoreboard sb;
  token_result_t   seen_word;
  int              sender_idle_pct = 0;
  int              receiver_stall_pct = 0;
  int unsigned     cycle_count = 0;
  logic [7:0]      reg_value [6];
  logic [7:0]      line_bytes[$];

  quoted_line_tokenizer DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .char_valid(char_valid), .char_stall(char_stall), .char_in(char_in),
    .result_valid(result_valid), .result_stall(result_stall),
    .category(category), .token_index(token_index),
    .token_location(token_location), .lower_char(lower_char),
    .token_done(token_done), .done_index(done_index),
    .done_integer(done_integer), .token_count(token_count),
    .token_overflow(token_overflow), .in_quotes(in_quotes)
  );

  always #5 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Random receiver stall
  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // Note accepted words on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (char_valid && !char_stall) sb.note_char(char_in);
      if (result_valid && !result_stall) begin
        seen_word.category       = category_t'(category);
        seen_word.token_index    = token_index;
        seen_word.token_location = token_location;
        seen_word.lower_char     = lower_char;
        seen_word.token_done     = token_done;
        seen_word.done_index     = done_index;
        seen_word.done_integer   = done_integer;
        seen_word.token_count    = token_count;
        seen_word.token_overflow = token_overflow;
        seen_word.in_quotes      = in_quotes;
        sb.check_result(seen_word);
      end
    end
  end

  // Offer one byte, idling at random first, and hold it until accepted
  task automatic send_char(input logic [7:0] c);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      char_valid = 1'b0;
      char_in = 8'($urandom);
      @(negedge clk);
    end
    char_valid = 1'b1;
    char_in = c;
    @(posedge clk);
    while (char_stall) @(posedge clk);
  endtask

  task automatic send_line();
    foreach (line_bytes[i]) send_char(line_bytes[i]);
  endtask

  // Stop sending until every owed result has arrived
  task automatic drain();
    @(negedge clk);
    char_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // APB write, then read back
  task automatic write_register(input reg_index_t idx, input logic [7:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = {24'd0, value};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_register(idx, value);
    reg_value[idx] = value;
    @(negedge clk);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[7:0] !== value) begin
      $error("prdata: expected 0x%0h, got 0x%0h", value, prdata[7:0]);
      sb.errors++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic load_registers(input logic [7:0] mark, sa, sb_, sc, sd, se);
    write_register(REG_HIDDEN_MARK, mark);
    write_register(REG_SEPARATOR_A, sa);
    write_register(REG_SEPARATOR_B, sb_);
    write_register(REG_SEPARATOR_C, sc);
    write_register(REG_SEPARATOR_D, sd);
    write_register(REG_SEPARATOR_E, se);
  endtask

  function automatic logic [7:0] pick_separator();
    logic [7:0] s;
    s = reg_value[1 + $urandom_range(4)];
    return (s == CHAR_EOL) ? CHAR_SPACE : s;
  endfunction

  function automatic logic [7:0] any_nonzero();
    return 8'($urandom_range(255, 1));
  endfunction

  function automatic void push_digits(int n);
    repeat (n) line_bytes.push_back(CHAR_ZERO + 8'($urandom_range(9)));
  endfunction

  // Region between two hidden marks; a quote when the mark is the line end
  function automatic void push_hidden_region();
    logic [7:0] mark;
    logic [7:0] b;
    mark = reg_value[REG_HIDDEN_MARK];
    if (mark == CHAR_EOL) begin
      line_bytes.push_back(CHAR_QUOTE);
      return;
    end
    line_bytes.push_back(mark);
    repeat ($urandom_range(4)) begin
      do b = any_nonzero(); while (b == mark);
      line_bytes.push_back(b);
    end
    line_bytes.push_back(mark);
  endfunction

  // Append one token of a random kind
  function automatic void add_token();
    int kind;
    kind = $urandom_range(9);
    case (kind)
      0, 1, 2: begin
        // signed decimal; long runs saturate
        if ($urandom_range(1)) line_bytes.push_back($urandom_range(1) ? CHAR_MINUS : CHAR_PLUS);
        push_digits(($urandom_range(3) == 0) ? $urandom_range(12, 9) : $urandom_range(6, 1));
        if ($urandom_range(3) == 0) line_bytes.push_back(8'($urandom_range(8'h7E, 8'h21)));
      end
      3: begin
        // quoted number with leading whitespace
        line_bytes.push_back(CHAR_QUOTE);
        repeat ($urandom_range(3))
          line_bytes.push_back($urandom_range(1) ? CHAR_SPACE :
                               8'($urandom_range(CHAR_CR, CHAR_TAB)));
        if ($urandom_range(1)) line_bytes.push_back($urandom_range(1) ? CHAR_MINUS : CHAR_PLUS);
        push_digits($urandom_range(11, 1));
        line_bytes.push_back(CHAR_QUOTE);
      end
      4: begin
        // letters around the case boundaries
        repeat ($urandom_range(8, 1)) line_bytes.push_back(8'($urandom_range(8'h7B, 8'h40)));
      end
      5: begin
        // quoted text holding separators, sometimes left open
        line_bytes.push_back(CHAR_QUOTE);
        repeat ($urandom_range(6, 1))
          line_bytes.push_back($urandom_range(1) ? pick_separator() :
                               8'($urandom_range(8'h7A, 8'h61)));
        if ($urandom_range(3) != 0) line_bytes.push_back(CHAR_QUOTE);
      end
      6: begin
        // marks inside a token do not end it
        push_digits($urandom_range(3, 1));
        push_hidden_region();
        push_digits($urandom_range(3, 1));
      end
      7: begin
        repeat ($urandom_range(5, 1)) line_bytes.push_back(any_nonzero());
      end
      8: push_hidden_region();
      default: line_bytes.push_back(CHAR_QUOTE);
    endcase
  endfunction

  // Mostly well-formed lines, some noise, some past the token table
  function automatic void build_line();
    int roll;
    int tokens;
    line_bytes.delete();
    roll = $urandom_range(19);
    if (roll < 2) begin
      repeat ($urandom_range(30, 1)) line_bytes.push_back(any_nonzero());
    end else begin
      tokens = (roll == 2) ? $urandom_range(40, 33) : $urandom_range(6);
      if ($urandom_range(1)) line_bytes.push_back(pick_separator());
      repeat (tokens) begin
        add_token();
        repeat ($urandom_range(2, 1)) line_bytes.push_back(pick_separator());
      end
    end
    line_bytes.push_back(CHAR_EOL);
  endfunction

  // Send random lines at the given idling, pausing once halfway
  task automatic run_phase(input int sender_pct, input int receiver_pct, input int budget);
    int sent;
    bit paused;
    sender_idle_pct = sender_pct;
    receiver_stall_pct = receiver_pct;
    sent = 0;
    paused = 0;
    while (sent < budget) begin
      build_line();
      send_line();
      sent += line_bytes.size();
      if (!paused && sent >= budget / 2) begin
        drain();
        paused = 1;
      end
    end
    drain();
  endtask

  initial begin
    sb = new();
    reg_value[REG_HIDDEN_MARK] = HIDDEN_MARK_RST;
    reg_value[REG_SEPARATOR_A] = SEPARATOR_A_RST;
    reg_value[REG_SEPARATOR_B] = SEPARATOR_B_RST;
    reg_value[REG_SEPARATOR_C] = SEPARATOR_C_RST;
    reg_value[REG_SEPARATOR_D] = SEPARATOR_D_RST;
    reg_value[REG_SEPARATOR_E] = SEPARATOR_E_RST;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed line at reset settings: quoted token with a space, hidden
    // region, quote inside a token, negative saturation
    line_bytes = '{8'h22, 8'h41, 8'h20, 8'h37, 8'h22, 8'h2C,
                   8'hFF, 8'h30, 8'hFF, 8'h5A, 8'h22, 8'h2C, 8'h22, 8'h09,
                   8'h2D, 8'h39, 8'h39, 8'h39, 8'h39, 8'h39, 8'h39, 8'h39,
                   8'h39, 8'h39, 8'h39, 8'h00};
    send_line();
    drain();

    run_phase(16, 68, 160);

    load_registers(8'h23, 8'h3B, 8'h7C, 8'h00, 8'h00, 8'h20);
    run_phase(68, 16, 160);

    load_registers(8'h00, 8'hFF, 8'h01, 8'h80, 8'h20, 8'h2C);
    run_phase(0, 0, 100);

    // One line past the line length so that positions wrap
    line_bytes.delete();
    repeat (1016) line_bytes.push_back(pick_separator());
    repeat (6) begin
      add_token();
      line_bytes.push_back(pick_separator());
    end
    line_bytes.push_back(CHAR_EOL);
    send_line();
    drain();

    load_registers(8'h22, 8'h2C, 8'h20, 8'h0B, 8'h2D, 8'h41);
    run_phase(0, 0, 90);

    // Let any stray result show up
    repeat (8) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
